// File: rtl/acceptance_rate_tracker_assert.svh
// Assertion macros shared by the rate tracker RTL
`ifndef ACCEPTANCE_RATE_TRACKER_ASSERT_SVH
`define ACCEPTANCE_RATE_TRACKER_ASSERT_SVH

// Checked on every rising edge outside reset
`define ART_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);

// Checked on every rising edge, reset included
`define ART_ASSERT_ALWAYS(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

// File: rtl/art_pkg.sv
// Shared types and constants of the acceptance rate tracker
`timescale 1ns / 1ps
package art_pkg;

  localparam int RATE_W  = 17;
  localparam int CNT_W   = 8;
  localparam int KEY_W   = 64;
  localparam int NUM_W   = 48;
  localparam int TOTAL_W = 32;
  localparam int WLEN_W  = 9;
  localparam int CFG_IDX_W = 2;

  localparam logic [RATE_W-1:0] ONE_Q16     = 17'h10000;
  localparam logic [RATE_W-1:0] ALPHA_RESET = 17'd6554;
  localparam logic [WLEN_W-1:0] WLEN_RESET  = 9'd64;

  localparam int WINDOW_DEPTH_DEF  = 256;
  localparam int TABLE_ENTRIES_DEF = 64;

  typedef enum logic [1:0] {
    OP_RECORD = 2'd0,
    OP_REMOVE = 2'd1,
    OP_QUERY  = 2'd2
  } op_t;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_GLOBAL_ALPHA  = 2'd0,
    CFG_REQUEST_ALPHA = 2'd1,
    CFG_WINDOW_LENGTH = 2'd2
  } cfg_idx_t;

  typedef enum logic [4:0] {
    ST_IDLE,
    ST_RATIO_GO,
    ST_RATIO_WAIT,
    ST_GLOB_GO,
    ST_GLOB_WAIT,
    ST_SKIP_GO,
    ST_SKIP_WAIT,
    ST_WIN_RD,
    ST_WIN_WR,
    ST_SCAN,
    ST_TBL_DECIDE,
    ST_ENT_RD,
    ST_ENT_GO,
    ST_ENT_WAIT,
    ST_ENT_WR,
    ST_WRATE_GO,
    ST_WRATE_WAIT,
    ST_TRATE_GO,
    ST_TRATE_WAIT,
    ST_OUT
  } state_t;

  typedef struct packed {
    logic              done;
    logic [RATE_W-1:0] value;
  } unit_res_t;

endpackage

// File: rtl/art_if.sv
// Handshake channels of the acceptance rate tracker
`timescale 1ns / 1ps
interface art_cmd_if import art_pkg::*; ();
  logic             valid;
  logic             ready;
  logic [1:0]       opcode;
  logic [KEY_W-1:0] request_key;
  logic [CNT_W-1:0] accepted_count;
  logic [CNT_W-1:0] attempted_count;
  logic             skip_used;

  modport source (output valid, opcode, request_key, accepted_count, attempted_count,
                  skip_used, input ready);
  modport sink (input valid, opcode, request_key, accepted_count, attempted_count,
                skip_used, output ready);
endinterface

interface art_rsp_if import art_pkg::*; ();
  logic              valid;
  logic              ready;
  logic [RATE_W-1:0] global_rate;
  logic [RATE_W-1:0] window_rate;
  logic [RATE_W-1:0] total_rate;
  logic [RATE_W-1:0] skip_rate;
  logic              skip_valid;
  logic [RATE_W-1:0] request_rate;
  logic              request_found;
  logic              table_full;

  modport source (output valid, global_rate, window_rate, total_rate, skip_rate,
                  skip_valid, request_rate, request_found, table_full, input ready);
  modport sink (input valid, global_rate, window_rate, total_rate, skip_rate,
                skip_valid, request_rate, request_found, table_full, output ready);
endinterface

interface art_cfg_if import art_pkg::*; ();
  logic                 valid;
  logic                 ready;
  logic [CFG_IDX_W-1:0] index;
  logic [RATE_W-1:0]    data;

  modport source (output valid, index, data, input ready);
  modport sink (input valid, index, data, output ready);
endinterface

// File: rtl/art_ram.sv
// Generic simple dual-port RAM with registered read
`timescale 1ns / 1ps
module art_ram #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 256,
  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic             re,
  input  logic [AW-1:0]    raddr,
  output logic [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

// File: rtl/art_div.sv
// Bit-serial Q1.16 ratio divider, one quotient bit per cycle
`timescale 1ns / 1ps
module art_div import art_pkg::*; (
  input  logic             clk,
  input  logic             rst,
  input  logic             start,
  input  logic [NUM_W-1:0] num,
  input  logic [NUM_W-1:0] den,
  output unit_res_t        res
);

  localparam int QW = RATE_W - 1;

  logic                  busy;
  logic [$clog2(QW)-1:0] step;
  logic [NUM_W:0]        rem;
  logic [NUM_W-1:0]      den_r;
  logic [QW-1:0]         quot;
  logic [NUM_W:0]        shifted;
  logic                  take;

  assign shifted = {rem[NUM_W-1:0], 1'b0};
  assign take    = shifted >= {1'b0, den_r};

  always_ff @(posedge clk) begin
    if (rst) begin
      busy     <= 1'b0;
      res.done <= 1'b0;
    end else begin
      res.done <= 1'b0;
      if (start) begin
        if (den == '0) begin
          res.value <= '0;
          res.done  <= 1'b1;
        end else if (num >= den) begin
          res.value <= ONE_Q16;
          res.done  <= 1'b1;
        end else begin
          busy  <= 1'b1;
          step  <= '0;
          rem   <= {1'b0, num};
          den_r <= den;
        end
      end else if (busy) begin
        rem  <= take ? (shifted - {1'b0, den_r}) : shifted;
        quot <= {quot[QW-2:0], take};
        step <= step + 1'b1;
        if (step == $clog2(QW)'(QW - 1)) begin
          busy      <= 1'b0;
          res.value <= {1'b0, quot[QW-2:0], take};
          res.done  <= 1'b1;
        end
      end
    end
  end

endmodule

// File: rtl/art_blend.sv
// EMA blend over one shared 17x17 multiplier, two products per update
`timescale 1ns / 1ps
module art_blend import art_pkg::*; (
  input  logic              clk,
  input  logic              rst,
  input  logic              start,
  input  logic [RATE_W-1:0] alpha,
  input  logic [RATE_W-1:0] sample,
  input  logic [RATE_W-1:0] old,
  output unit_res_t         res
);

  localparam int PW = 2 * RATE_W;
  localparam logic [PW-1:0] HALF = PW'(32768);

  logic              v1, v2, v3;
  logic [RATE_W-1:0] a_r, s_r, o_r;
  logic [RATE_W-1:0] mul_a, mul_b;
  logic [PW-1:0]     prod, acc, total;

  assign mul_a = v1 ? a_r : (ONE_Q16 - a_r);
  assign mul_b = v1 ? s_r : o_r;
  assign total = acc + prod;

  always_ff @(posedge clk) begin
    if (rst) begin
      v1       <= 1'b0;
      v2       <= 1'b0;
      v3       <= 1'b0;
      res.done <= 1'b0;
    end else begin
      v1       <= start;
      v2       <= v1;
      v3       <= v2;
      res.done <= v3;
      if (start) begin
        // alpha above one acts as one
        a_r <= (alpha > ONE_Q16) ? ONE_Q16 : alpha;
        s_r <= sample;
        o_r <= old;
      end
      if (v1 || v2) begin
        prod <= mul_a * mul_b;
      end
      if (v2) begin
        acc <= prod + HALF;
      end
      if (v3) begin
        res.value <= total[PW-2:RATE_W-1];
      end
    end
  end

endmodule

// File: rtl/acceptance_rate_tracker.sv
// Acceptance rate tracker: EMAs, window and cumulative rates, keyed request table
//
//   channel | dir | payload
//   cmd     | in  | opcode, request_key, accepted_count, attempted_count, skip_used
//   rsp     | out | global/window/total/skip/request rates and flags
//   cfg     | in  | index, data (global_alpha, request_alpha, window_length)
//
// One item at a time. The run time of an item is set by the serial divider (three
// ratios per record) and by the key scan (one table entry per cycle).
// Synchronous reset clears all state at once; there is no clearing pass.
// A finished result waits in the rsp register; the next item is taken meanwhile.
`timescale 1ns / 1ps
module acceptance_rate_tracker import art_pkg::*; #(
  parameter int WINDOW_DEPTH  = WINDOW_DEPTH_DEF,
  parameter int TABLE_ENTRIES = TABLE_ENTRIES_DEF
) (
  input  logic      clk,
  input  logic      rst,
  art_cmd_if.sink   cmd,
  art_rsp_if.source rsp,
  art_cfg_if.sink   cfg
);

`include "acceptance_rate_tracker_assert.svh"

  localparam int PW  = (WINDOW_DEPTH > 1) ? $clog2(WINDOW_DEPTH) : 1;
  localparam int LW  = $clog2(WINDOW_DEPTH + 1);
  localparam int CW  = (LW > WLEN_W) ? LW : WLEN_W;
  localparam int SW  = CNT_W + $clog2(WINDOW_DEPTH);
  localparam int TW  = (TABLE_ENTRIES > 1) ? $clog2(TABLE_ENTRIES) : 1;
  localparam int SCW = $clog2(TABLE_ENTRIES + 1);

  state_t state, state_next;

  // configuration
  logic [RATE_W-1:0] global_alpha, request_alpha;
  logic [WLEN_W-1:0] window_length;
  logic [CW-1:0]     wl_ext, eff_w;
  logic [LW-1:0]     eff_len;

  // item
  logic [1:0]        op_r;
  logic [KEY_W-1:0]  key_r;
  logic [CNT_W-1:0]  acc_r, att_r;
  logic              skip_r;
  logic [RATE_W-1:0] ratio;

  // global state
  logic [RATE_W-1:0]  global_avg, skip_avg;
  logic               global_seeded, skip_seeded;
  logic [NUM_W-1:0]   sum_acc_all, sum_att_all;
  logic [NUM_W:0]     sum_acc_inc, sum_att_inc;
  logic [TOTAL_W-1:0] record_total;

  // window
  logic [PW-1:0]  win_pos, pos_w, pos_adv;
  logic [LW-1:0]  win_fill;
  logic [SW-1:0]  win_sum_acc, win_sum_att;
  logic [2*CNT_W-1:0] win_rdata;
  logic           win_re, win_we;

  // table
  logic [TABLE_ENTRIES-1:0] entry_valid;
  logic [SCW-1:0]    scan_idx;
  logic              pend;
  logic [TW-1:0]     pend_idx, found_idx, free_idx, slot;
  logic              found_v, free_v, scan_more;
  logic [KEY_W-1:0]  key_rdata;
  logic [RATE_W-1:0] avg_rdata;
  logic              key_re, key_we, avg_re, avg_we;

  // shared units
  logic              div_start, blend_start;
  logic [NUM_W-1:0]  div_num, div_den;
  logic [RATE_W-1:0] blend_alpha, blend_old;
  unit_res_t         div_res, blend_res;

  // results
  logic              full_r, req_found;
  logic [RATE_W-1:0] req_rate, wrate, trate;
  logic              rsp_valid;
  logic              rsp_free;

  assign wl_ext  = CW'(window_length);
  assign eff_w   = (wl_ext == '0) ? CW'(1) :
                   (wl_ext > CW'(WINDOW_DEPTH)) ? CW'(WINDOW_DEPTH) : wl_ext;
  assign eff_len = eff_w[LW-1:0];

  assign pos_w   = (LW'(win_pos) >= eff_len) ? '0 : win_pos;
  assign pos_adv = ((LW'(win_pos) + LW'(1)) == eff_len) ? '0 : (win_pos + 1'b1);

  assign sum_acc_inc = {1'b0, sum_acc_all} + (NUM_W + 1)'(acc_r);
  assign sum_att_inc = {1'b0, sum_att_all} + (NUM_W + 1)'(att_r);

  assign scan_more = scan_idx < SCW'(TABLE_ENTRIES);
  assign slot      = found_v ? found_idx : free_idx;
  assign rsp_free  = !rsp_valid || rsp.ready;

  assign cfg.ready = 1'b1;

  art_div u_div (
    .clk   (clk),
    .rst   (rst),
    .start (div_start),
    .num   (div_num),
    .den   (div_den),
    .res   (div_res)
  );

  art_blend u_blend (
    .clk    (clk),
    .rst    (rst),
    .start  (blend_start),
    .alpha  (blend_alpha),
    .sample (ratio),
    .old    (blend_old),
    .res    (blend_res)
  );

  art_ram #(.WIDTH(2 * CNT_W), .DEPTH(WINDOW_DEPTH)) u_win_ram (
    .clk   (clk),
    .we    (win_we),
    .waddr (win_pos),
    .wdata ({acc_r, att_r}),
    .re    (win_re),
    .raddr (pos_w),
    .rdata (win_rdata)
  );

  art_ram #(.WIDTH(KEY_W), .DEPTH(TABLE_ENTRIES)) u_key_ram (
    .clk   (clk),
    .we    (key_we),
    .waddr (slot),
    .wdata (key_r),
    .re    (key_re),
    .raddr (scan_idx[TW-1:0]),
    .rdata (key_rdata)
  );

  art_ram #(.WIDTH(RATE_W), .DEPTH(TABLE_ENTRIES)) u_avg_ram (
    .clk   (clk),
    .we    (avg_we),
    .waddr (slot),
    .wdata (found_v ? req_rate : ratio),
    .re    (avg_re),
    .raddr (found_idx),
    .rdata (avg_rdata)
  );

  // next state
  always_comb begin
    state_next = state;
    unique case (state)
      ST_IDLE:       if (cmd.valid) begin
                       state_next = (cmd.opcode == OP_RECORD) ? ST_RATIO_GO : ST_SCAN;
                     end
      ST_RATIO_GO:   state_next = ST_RATIO_WAIT;
      ST_RATIO_WAIT: if (div_res.done) state_next = ST_GLOB_GO;
      ST_GLOB_GO:    state_next = global_seeded ? ST_GLOB_WAIT : ST_SKIP_GO;
      ST_GLOB_WAIT:  if (blend_res.done) state_next = ST_SKIP_GO;
      ST_SKIP_GO:    state_next = (skip_r && skip_seeded) ? ST_SKIP_WAIT : ST_WIN_RD;
      ST_SKIP_WAIT:  if (blend_res.done) state_next = ST_WIN_RD;
      ST_WIN_RD:     state_next = ST_WIN_WR;
      ST_WIN_WR:     state_next = ST_SCAN;
      ST_SCAN:       if (!scan_more && pend) state_next = ST_TBL_DECIDE;
      ST_TBL_DECIDE: begin
        if (op_r == OP_RECORD) begin
          state_next = found_v ? ST_ENT_RD : (free_v ? ST_ENT_WR : ST_WRATE_GO);
        end else if (op_r == OP_REMOVE) begin
          state_next = ST_WRATE_GO;
        end else begin
          state_next = found_v ? ST_ENT_RD : ST_WRATE_GO;
        end
      end
      ST_ENT_RD:     state_next = ST_ENT_GO;
      ST_ENT_GO:     state_next = (op_r == OP_RECORD) ? ST_ENT_WAIT : ST_WRATE_GO;
      ST_ENT_WAIT:   if (blend_res.done) state_next = ST_ENT_WR;
      ST_ENT_WR:     state_next = ST_WRATE_GO;
      ST_WRATE_GO:   state_next = ST_WRATE_WAIT;
      ST_WRATE_WAIT: if (div_res.done) state_next = ST_TRATE_GO;
      ST_TRATE_GO:   state_next = ST_TRATE_WAIT;
      ST_TRATE_WAIT: if (div_res.done) state_next = ST_OUT;
      ST_OUT:        if (rsp_free) state_next = ST_IDLE;
      default:       state_next = ST_IDLE;
    endcase
  end

  // control strobes and unit operands
  always_comb begin
    cmd.ready   = 1'b0;
    div_start   = 1'b0;
    div_num     = NUM_W'(acc_r);
    div_den     = NUM_W'(att_r);
    blend_start = 1'b0;
    blend_alpha = global_alpha;
    blend_old   = global_avg;
    win_re      = 1'b0;
    win_we      = 1'b0;
    key_re      = 1'b0;
    key_we      = 1'b0;
    avg_re      = 1'b0;
    avg_we      = 1'b0;
    unique case (state)
      ST_IDLE:     cmd.ready = 1'b1;
      ST_RATIO_GO: div_start = 1'b1;
      ST_GLOB_GO:  blend_start = global_seeded;
      ST_SKIP_GO: begin
        blend_start = skip_r && skip_seeded;
        blend_old   = skip_avg;
      end
      ST_WIN_RD:   win_re = 1'b1;
      ST_WIN_WR:   win_we = 1'b1;
      ST_SCAN:     key_re = scan_more;
      ST_ENT_RD:   avg_re = 1'b1;
      ST_ENT_GO: begin
        blend_start = op_r == OP_RECORD;
        blend_alpha = request_alpha;
        blend_old   = avg_rdata;
      end
      ST_ENT_WR: begin
        avg_we = 1'b1;
        key_we = !found_v;
      end
      ST_WRATE_GO: begin
        div_start = 1'b1;
        div_num   = NUM_W'(win_sum_acc);
        div_den   = NUM_W'(win_sum_att);
      end
      ST_TRATE_GO: begin
        div_start = 1'b1;
        div_num   = sum_acc_all;
        div_den   = sum_att_all;
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state         <= ST_IDLE;
      global_alpha  <= ALPHA_RESET;
      request_alpha <= ALPHA_RESET;
      window_length <= WLEN_RESET;
      global_avg    <= '0;
      global_seeded <= 1'b0;
      skip_avg      <= '0;
      skip_seeded   <= 1'b0;
      sum_acc_all   <= '0;
      sum_att_all   <= '0;
      record_total  <= '0;
      win_pos       <= '0;
      win_fill      <= '0;
      win_sum_acc   <= '0;
      win_sum_att   <= '0;
      entry_valid   <= '0;
      rsp_valid     <= 1'b0;
      scan_idx      <= '0;
      pend          <= 1'b0;
      found_v       <= 1'b0;
      free_v        <= 1'b0;
    end else begin
      state <= state_next;
      if (rsp_valid && rsp.ready) begin
        rsp_valid <= 1'b0;
      end

      unique case (state)
        ST_IDLE: if (cmd.valid) begin
          op_r      <= cmd.opcode;
          key_r     <= cmd.request_key;
          acc_r     <= cmd.accepted_count;
          att_r     <= cmd.attempted_count;
          skip_r    <= cmd.skip_used;
          full_r    <= 1'b0;
          req_found <= 1'b0;
          req_rate  <= '0;
          scan_idx  <= '0;
          pend      <= 1'b0;
          found_v   <= 1'b0;
          free_v    <= 1'b0;
        end
        ST_RATIO_WAIT: if (div_res.done) ratio <= div_res.value;
        ST_GLOB_GO: if (!global_seeded) begin
          global_avg    <= ratio;
          global_seeded <= 1'b1;
        end
        ST_GLOB_WAIT: if (blend_res.done) global_avg <= blend_res.value;
        ST_SKIP_GO: if (skip_r && !skip_seeded) begin
          skip_avg    <= ratio;
          skip_seeded <= 1'b1;
        end
        ST_SKIP_WAIT: if (blend_res.done) skip_avg <= blend_res.value;
        ST_WIN_RD: begin
          win_pos      <= pos_w;
          sum_acc_all  <= sum_acc_inc[NUM_W] ? '1 : sum_acc_inc[NUM_W-1:0];
          sum_att_all  <= sum_att_inc[NUM_W] ? '1 : sum_att_inc[NUM_W-1:0];
          if (record_total != '1) record_total <= record_total + 1'b1;
        end
        ST_WIN_WR: begin
          // full window: drop the oldest record from the running sums
          if (win_fill >= eff_len) begin
            win_sum_acc <= win_sum_acc - SW'(win_rdata[2*CNT_W-1:CNT_W]) + SW'(acc_r);
            win_sum_att <= win_sum_att - SW'(win_rdata[CNT_W-1:0]) + SW'(att_r);
            win_fill    <= eff_len;
          end else begin
            win_sum_acc <= win_sum_acc + SW'(acc_r);
            win_sum_att <= win_sum_att + SW'(att_r);
            win_fill    <= win_fill + 1'b1;
          end
          win_pos <= pos_adv;
        end
        ST_SCAN: begin
          if (scan_more) begin
            scan_idx <= scan_idx + 1'b1;
            pend     <= 1'b1;
            pend_idx <= scan_idx[TW-1:0];
            if (!entry_valid[scan_idx[TW-1:0]] && !free_v) begin
              free_v   <= 1'b1;
              free_idx <= scan_idx[TW-1:0];
            end
          end else begin
            pend <= 1'b0;
          end
          if (pend && entry_valid[pend_idx] && key_rdata == key_r) begin
            found_v   <= 1'b1;
            found_idx <= pend_idx;
          end
        end
        ST_TBL_DECIDE: begin
          if (op_r == OP_RECORD) begin
            if (!found_v && !free_v) full_r <= 1'b1;
          end else if (op_r == OP_REMOVE) begin
            if (found_v) entry_valid[found_idx] <= 1'b0;
          end
        end
        ST_ENT_GO: if (op_r != OP_RECORD) begin
          req_rate  <= avg_rdata;
          req_found <= 1'b1;
        end
        ST_ENT_WAIT: if (blend_res.done) req_rate <= blend_res.value;
        ST_ENT_WR: begin
          entry_valid[slot] <= 1'b1;
          req_found         <= 1'b1;
          if (!found_v) req_rate <= ratio;
        end
        ST_WRATE_WAIT: if (div_res.done) wrate <= div_res.value;
        ST_TRATE_WAIT: if (div_res.done) trate <= div_res.value;
        ST_OUT: if (rsp_free) begin
          rsp_valid         <= 1'b1;
          rsp.global_rate   <= global_avg;
          rsp.window_rate   <= wrate;
          rsp.total_rate    <= trate;
          rsp.skip_rate     <= skip_avg;
          rsp.skip_valid    <= skip_seeded;
          rsp.request_rate  <= req_rate;
          rsp.request_found <= req_found;
          rsp.table_full    <= full_r;
        end
        default: ;
      endcase

      if (cfg.valid) begin
        unique case (cfg.index)
          CFG_GLOBAL_ALPHA:  global_alpha  <= cfg.data;
          CFG_REQUEST_ALPHA: request_alpha <= cfg.data;
          CFG_WINDOW_LENGTH: begin
            // new length empties the window
            window_length <= cfg.data[WLEN_W-1:0];
            win_pos       <= '0;
            win_fill      <= '0;
            win_sum_acc   <= '0;
            win_sum_att   <= '0;
          end
          default: ;
        endcase
      end
    end
  end

  assign rsp.valid = rsp_valid;

  `ART_ASSERT(a_fill_bound, win_fill <= eff_len, "window fill beyond window length")
  `ART_ASSERT(a_empty_window, (win_fill == '0) |-> (win_sum_acc == '0 && win_sum_att == '0), "empty window holds nonzero sums")
  `ART_ASSERT(a_skip_after_global, skip_seeded |-> global_seeded, "skip average seeded before global")
  `ART_ASSERT(a_div_done_wait, div_res.done |-> (state == ST_RATIO_WAIT || state == ST_WRATE_WAIT || state == ST_TRATE_WAIT), "divider result outside a wait state")
  `ART_ASSERT(a_blend_bound, blend_res.done |-> (blend_res.value <= ONE_Q16), "blended rate above one")

endmodule
